/* design/icc_pkg.sv */
// ----------------------------------------------------------------------------
// icc_pkg
// shared types and constants of the input channel conditioner
// ----------------------------------------------------------------------------
`default_nettype none

package icc_pkg;

    // configuration register indexes
    localparam logic [2:0] CFG_ENABLED  = 3'd0;
    localparam logic [2:0] CFG_MODE     = 3'd1;
    localparam logic [2:0] CFG_ACT_HIGH = 3'd2;
    localparam logic [2:0] CFG_DEFAULT  = 3'd3;
    localparam logic [2:0] CFG_WIN_LOW  = 3'd4;
    localparam logic [2:0] CFG_WIN_HIGH = 3'd5;
    localparam logic [2:0] CFG_DEBOUNCE = 3'd6;

    // channel modes
    localparam logic [1:0] MODE_DIGITAL = 2'd0;
    localparam logic [1:0] MODE_VALUE   = 2'd1;
    localparam logic [1:0] MODE_WINDOW  = 2'd2;

    // countdown idle code (minus one)
    localparam logic [7:0] CD_IDLE = 8'hFF;

    typedef struct packed {
        logic       pin_level;
        logic [7:0] adc_sample;
    } t_in;

    typedef struct packed {
        logic [7:0] logic_value;
        logic [7:0] filtered_value;
        logic       settling;
    } t_out;

    // countdown running when in 1..127
    function automatic logic is_running(input logic [7:0] cd);
        is_running = (cd != 8'd0) && !cd[7];
    endfunction

endpackage

`default_nettype wire

/* design/input_channel_conditioner_core.sv */
// ----------------------------------------------------------------------------
// input_channel_conditioner_core
// one input channel: pin debounce, moving average, window switch
// ----------------------------------------------------------------------------
// usage
//   one instance per channel. each tick word carries a pin level and an adc
//   sample on a valid/ready input channel; exactly one result word per tick
//   leaves on a valid/ready output channel.
//   the whole tick update (history shift, running sum, reciprocal multiply
//   for the average, window compare, countdown) is one combinational pass
//   from the channel state, so a tick is taken every cycle while o_in_ready
//   is high; the result word is registered in the output buffer.
//   results sit in a two-word output buffer, so the input keeps taking
//   ticks while one result waits; only with both buffer words held by a
//   stalled receiver does o_in_ready drop.
//   configuration is a plain write port (enable, index, data); any write to
//   a known index re-initializes the channel state from the new settings,
//   unknown indexes are ignored. write only while the block is idle.
//   synchronous reset loads the register defaults and initializes the
//   channel (digital mode, logic value 0, history cleared); no sweep needed.
// ----------------------------------------------------------------------------
`default_nettype none

module input_channel_conditioner_core
    import icc_pkg::*;
#(
    parameter int AVERAGE_TAPS = 4
)(
    input  wire        i_clk,
    input  wire        i_rst_n,
    // tick input
    input  wire        i_in_valid,
    output logic       o_in_ready,
    input  t_in        i_in,
    // result output
    output logic       o_out_valid,
    input  wire        i_out_ready,
    output t_out       o_out,
    // configuration write
    input  wire        i_cfg_we,
    input  wire  [2:0] i_cfg_index,
    input  wire  [7:0] i_cfg_data
);

    // running sum width and reciprocal for the exact floor divide by taps
    localparam int TapBits = $clog2(AVERAGE_TAPS);
    localparam int SumW    = 8 + TapBits;
    localparam int Shift   = SumW + TapBits;
    localparam int RecipW  = Shift + 1;
    localparam logic [RecipW-1:0] Recip =
        RecipW'(((1 << Shift) + AVERAGE_TAPS - 1) / AVERAGE_TAPS);
    localparam int ProdW   = SumW + RecipW;

    // configuration registers
    logic       r_enabled,  n_enabled;
    logic [1:0] r_mode,     n_mode;
    logic       r_act_high, n_act_high;
    logic [7:0] r_default,  n_default;
    logic [7:0] r_win_low,  n_win_low;
    logic [7:0] r_win_high, n_win_high;
    logic [6:0] r_debounce, n_debounce;

    // channel state
    logic [7:0]      r_last_raw, n_last_raw;
    logic [7:0]      r_phys,     n_phys;
    logic [7:0]      r_logic,    n_logic;
    logic [7:0]      r_cd,       n_cd;
    logic [7:0]      r_hist [AVERAGE_TAPS];
    logic [7:0]      n_hist [AVERAGE_TAPS];
    logic [SumW-1:0] r_sum,      n_sum;

    logic in_acc;
    logic buf_ready;
    t_out result;

    // average datapath
    logic [SumW-1:0]  sum_next;
    logic [ProdW-1:0] prod;
    logic [7:0]       avg;
    logic             in_win;
    logic [7:0]       load_val;

    assign in_acc   = i_in_valid && buf_ready;
    assign o_in_ready = buf_ready;

    // sum drops the oldest tap and adds the new sample
    assign sum_next = r_sum + SumW'(i_in.adc_sample) - SumW'(r_hist[0]);
    assign prod     = {{RecipW{1'b0}}, sum_next} * {{SumW{1'b0}}, Recip};
    assign avg      = prod[Shift +: 8];
    assign in_win   = (r_win_low <= avg) && (avg <= r_win_high);
    // zero debounce acts as one
    assign load_val = (r_debounce == 7'd0) ? 8'd1 : {1'b0, r_debounce};

    always_comb begin
        logic cfg_hit;
        logic on_high;
        logic do_tick;
        logic expire;

        n_enabled  = r_enabled;
        n_mode     = r_mode;
        n_act_high = r_act_high;
        n_default  = r_default;
        n_win_low  = r_win_low;
        n_win_high = r_win_high;
        n_debounce = r_debounce;
        n_last_raw = r_last_raw;
        n_phys     = r_phys;
        n_logic    = r_logic;
        n_cd       = r_cd;
        n_sum      = r_sum;
        n_hist     = r_hist;
        cfg_hit    = 1'b0;
        on_high    = 1'b0;
        do_tick    = 1'b0;
        expire     = 1'b0;

        if (i_cfg_we) begin
            cfg_hit = 1'b1;
            case (i_cfg_index)
                CFG_ENABLED:  n_enabled  = i_cfg_data[0];
                CFG_MODE:     n_mode     = i_cfg_data[1:0];
                CFG_ACT_HIGH: n_act_high = i_cfg_data[0];
                CFG_DEFAULT:  n_default  = i_cfg_data;
                CFG_WIN_LOW:  n_win_low  = i_cfg_data;
                CFG_WIN_HIGH: n_win_high = i_cfg_data;
                CFG_DEBOUNCE: n_debounce = i_cfg_data[6:0];
                default:      cfg_hit    = 1'b0;
            endcase
        end

        if (cfg_hit) begin
            // re-init from the new settings
            n_logic = n_default;
            case (n_mode)
                MODE_DIGITAL: begin
                    on_high    = n_act_high ^ (n_default != 8'd1);
                    n_last_raw = {7'd0, on_high};
                end
                MODE_VALUE, MODE_WINDOW: n_last_raw = n_default;
                default:                 n_last_raw = 8'd0;
            endcase
            n_phys = n_last_raw;
            n_cd   = CD_IDLE;
            n_sum  = '0;
            for (int k = 0; k < AVERAGE_TAPS; k++) begin
                n_hist[k] = 8'd0;
            end
        end else if (in_acc && r_enabled) begin
            case (r_mode)
                MODE_DIGITAL: begin
                    do_tick = 1'b1;
                    if (r_last_raw != {7'd0, i_in.pin_level}) begin
                        n_last_raw = {7'd0, i_in.pin_level};
                        n_cd       = load_val;
                    end
                end
                MODE_VALUE, MODE_WINDOW: begin
                    do_tick = 1'b1;
                    for (int k = 0; k < AVERAGE_TAPS - 1; k++) begin
                        n_hist[k] = r_hist[k+1];
                    end
                    n_hist[AVERAGE_TAPS-1] = i_in.adc_sample;
                    n_sum = sum_next;
                    if (r_last_raw != avg) begin
                        n_last_raw = avg;
                        if (r_mode == MODE_VALUE) begin
                            n_phys  = avg;
                            n_logic = avg;
                            n_cd    = CD_IDLE;
                        end else if (r_phys != {7'd0, in_win}) begin
                            n_phys = {7'd0, in_win};
                            n_cd   = load_val;
                        end
                    end
                end
                default: do_tick = 1'b0;
            endcase

            // countdown step, expiry commits the settled level
            if (do_tick && is_running(n_cd)) begin
                n_cd = n_cd - 8'd1;
                if (n_cd == 8'd0) begin
                    n_cd   = CD_IDLE;
                    expire = 1'b1;
                end
            end
            if (expire) begin
                if (r_mode == MODE_DIGITAL) begin
                    n_phys  = n_last_raw;
                    n_logic = {7'd0, (n_last_raw != 8'd0) == r_act_high};
                end else begin
                    n_logic = {7'd0, n_phys != 8'd0};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled  <= 1'b0;
            r_mode     <= MODE_DIGITAL;
            r_act_high <= 1'b1;
            r_default  <= 8'd0;
            r_win_low  <= 8'd0;
            r_win_high <= 8'hFF;
            r_debounce <= 7'd5;
            // init with the defaults: "on" is high, default off, so pin low
            r_last_raw <= 8'd0;
            r_phys     <= 8'd0;
            r_logic    <= 8'd0;
            r_cd       <= CD_IDLE;
            r_sum      <= '0;
            for (int k = 0; k < AVERAGE_TAPS; k++) begin
                r_hist[k] <= 8'd0;
            end
        end else begin
            r_enabled  <= n_enabled;
            r_mode     <= n_mode;
            r_act_high <= n_act_high;
            r_default  <= n_default;
            r_win_low  <= n_win_low;
            r_win_high <= n_win_high;
            r_debounce <= n_debounce;
            r_last_raw <= n_last_raw;
            r_phys     <= n_phys;
            r_logic    <= n_logic;
            r_cd       <= n_cd;
            r_sum      <= n_sum;
            r_hist     <= n_hist;
        end
    end

    // result word reflects the state after this tick
    assign result.logic_value    = n_logic;
    assign result.filtered_value = n_last_raw;
    assign result.settling       = is_running(n_cd);

    icc_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (in_acc),
        .o_ready (buf_ready),
        .i_data  (result),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out)
    );

    // any known register write leaves the countdown idle
    a_cfg_idles_cd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we && (i_cfg_index <= CFG_DEBOUNCE) |=> r_cd == CD_IDLE)
        else $error("countdown running after config write");

    // value mode never runs a countdown
    a_value_no_cd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode == MODE_VALUE |-> r_cd == CD_IDLE)
        else $error("countdown running in value mode");

    // disabled channel keeps its state across ticks
    a_disabled_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && !r_enabled && !i_cfg_we |=>
            $stable(r_logic) && $stable(r_last_raw) && $stable(r_cd))
        else $error("disabled channel state moved");

    // countdown only moves on a tick or a config write
    a_cd_needs_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !in_acc && !i_cfg_we |=> $stable(r_cd) && $stable(r_logic))
        else $error("state moved without tick");

endmodule

`default_nettype wire

/* design/icc_out_buf.sv */
// ----------------------------------------------------------------------------
// icc_out_buf
// two-entry result buffer: output register plus skid register
// ----------------------------------------------------------------------------
`default_nettype none

module icc_out_buf
    import icc_pkg::*;
(
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_valid,
    output logic o_ready,
    input  t_out i_data,
    output logic o_valid,
    input  wire  i_ready,
    output t_out o_data
);

    logic r_main_valid;
    logic r_skid_valid;
    t_out r_main;
    t_out r_skid;
    logic push;
    logic pop;

    assign o_ready = !r_skid_valid;
    assign o_valid = r_main_valid;
    assign o_data  = r_main;
    assign push    = i_valid && o_ready;
    assign pop     = r_main_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (pop) begin
            if (r_skid_valid) begin
                r_main       <= r_skid;
                r_skid_valid <= 1'b0;
            end else begin
                r_main_valid <= push;
                r_main       <= i_data;
            end
        end else if (!r_main_valid) begin
            r_main_valid <= push;
            r_main       <= i_data;
        end else if (push) begin
            r_skid       <= i_data;
            r_skid_valid <= 1'b1;
        end
    end

    // skid word only exists behind a waiting main word
    a_skid_behind_main: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_main_valid)
        else $error("skid word without main word");

    // stalled word stays put
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_main_valid && !i_ready |=> r_main_valid && $stable(r_main))
        else $error("stalled word changed");

    // a full buffer that is drained hands over the skid word
    a_drain_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid && i_ready |=> r_main_valid && !r_skid_valid
                                    && r_main == $past(r_skid))
        else $error("skid word lost");

endmodule

`default_nettype wire
